FILE: hw/rtl/hsv2rgb_pkg.sv
// Shared types, constants and the fixed-point level multiply for the HSV to RGB pipeline.
package hsv2rgb_pkg;

    // Hue steps per sextant, full channel level, remainder scale
    localparam int unsigned SEXTANT_STEPS = 43;
    localparam logic [7:0]  FULL_LEVEL    = 8'd255;
    localparam int unsigned SEXTANT_SCALE = 6;
    localparam int unsigned LEVEL_SHIFT   = 8;

    // Hue thresholds where each sextant starts
    localparam logic [7:0] HUE_BASE_1 = 8'(1 * SEXTANT_STEPS);
    localparam logic [7:0] HUE_BASE_2 = 8'(2 * SEXTANT_STEPS);
    localparam logic [7:0] HUE_BASE_3 = 8'(3 * SEXTANT_STEPS);
    localparam logic [7:0] HUE_BASE_4 = 8'(4 * SEXTANT_STEPS);
    localparam logic [7:0] HUE_BASE_5 = 8'(5 * SEXTANT_STEPS);

    // Sextant codes, named after the hue span they cover
    localparam logic [2:0] SXT_RED_YEL = 3'd0;
    localparam logic [2:0] SXT_YEL_GRN = 3'd1;
    localparam logic [2:0] SXT_GRN_CYN = 3'd2;
    localparam logic [2:0] SXT_CYN_BLU = 3'd3;
    localparam logic [2:0] SXT_BLU_MAG = 3'd4;
    localparam logic [2:0] SXT_MAG_RED = 3'd5;

    // After stage 1: sextant and scaled remainder
    typedef struct packed {
        logic       gray;
        logic [2:0] region;
        logic [7:0] rem;
        logic [7:0] sat;
        logic [7:0] val;
    } sxt_t;

    // After stage 2: p and the two saturation products
    typedef struct packed {
        logic       gray;
        logic [2:0] region;
        logic [7:0] val;
        logic [7:0] p;
        logic [7:0] sat_rem;
        logic [7:0] sat_inv;
    } scl_t;

    // After stage 3: all four candidate levels
    typedef struct packed {
        logic       gray;
        logic [2:0] region;
        logic [7:0] val;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } lvl_t;

    // Output pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // (x * k) >> 8, truncated to 8 bits
    function automatic logic [7:0] level_mul(input logic [7:0] x, input logic [7:0] k);
        logic [15:0] prod;
        prod = 16'(x) * 16'(k);
        return prod[LEVEL_SHIFT +: 8];
    endfunction

endpackage

FILE: hw/rtl/hsv2rgb_sextant.sv
// Stage 1: splits hue into sextant and scaled remainder, flags the gray case.
module hsv2rgb_sextant import hsv2rgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] hue,
    input  logic [7:0] sat,
    input  logic [7:0] val,
    output logic       out_valid,
    input  logic       out_ready,
    output sxt_t       out_data
);

    logic       valid_reg;
    sxt_t       data_reg;
    sxt_t       data_next;
    logic [2:0] region;
    logic [7:0] base;
    logic [7:0] rem_raw;

    // Sextant by threshold compare, no divider needed
    always_comb begin
        if (hue >= HUE_BASE_5) begin
            region = SXT_MAG_RED;
            base   = HUE_BASE_5;
        end else if (hue >= HUE_BASE_4) begin
            region = SXT_BLU_MAG;
            base   = HUE_BASE_4;
        end else if (hue >= HUE_BASE_3) begin
            region = SXT_CYN_BLU;
            base   = HUE_BASE_3;
        end else if (hue >= HUE_BASE_2) begin
            region = SXT_GRN_CYN;
            base   = HUE_BASE_2;
        end else if (hue >= HUE_BASE_1) begin
            region = SXT_YEL_GRN;
            base   = HUE_BASE_1;
        end else begin
            region = SXT_RED_YEL;
            base   = 8'd0;
        end
        rem_raw = hue - base;
    end

    // Remainder is at most 42, so times six stays within 8 bits
    always_comb begin
        data_next.gray   = (sat == 8'd0);
        data_next.region = region;
        data_next.rem    = 8'(rem_raw * SEXTANT_SCALE);
        data_next.sat    = sat;
        data_next.val    = val;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/hsv2rgb_scale.sv
// Stage 2: p and the saturation-weighted remainder products.
module hsv2rgb_scale import hsv2rgb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sxt_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output scl_t out_data
);

    logic valid_reg;
    scl_t data_reg;
    scl_t data_next;

    // Three independent 8x8 products
    always_comb begin
        data_next.gray    = in_data.gray;
        data_next.region  = in_data.region;
        data_next.val     = in_data.val;
        data_next.p       = level_mul(in_data.val, FULL_LEVEL - in_data.sat);
        data_next.sat_rem = level_mul(in_data.sat, in_data.rem);
        data_next.sat_inv = level_mul(in_data.sat, FULL_LEVEL - in_data.rem);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/hsv2rgb_level.sv
// Stage 3: falling level q and rising level t.
module hsv2rgb_level import hsv2rgb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  scl_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output lvl_t out_data
);

    logic valid_reg;
    lvl_t data_reg;
    lvl_t data_next;

    // Second multiply level: scale value by the inverted products
    always_comb begin
        data_next.gray   = in_data.gray;
        data_next.region = in_data.region;
        data_next.val    = in_data.val;
        data_next.p      = in_data.p;
        data_next.q      = level_mul(in_data.val, FULL_LEVEL - in_data.sat_rem);
        data_next.t      = level_mul(in_data.val, FULL_LEVEL - in_data.sat_inv);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/hsv2rgb_perm.sv
// Stage 4: maps v, p, q, t onto the channels by sextant; output register.
module hsv2rgb_perm import hsv2rgb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  lvl_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rgb_t out_data
);

    logic valid_reg;
    rgb_t data_reg;
    rgb_t data_next;

    // Channel permutation; gray pixels bypass it
    always_comb begin
        if (in_data.gray) begin
            data_next.red   = in_data.val;
            data_next.green = in_data.val;
            data_next.blue  = in_data.val;
        end else begin
            case (in_data.region)
                SXT_RED_YEL: begin
                    data_next.red   = in_data.val;
                    data_next.green = in_data.t;
                    data_next.blue  = in_data.p;
                end
                SXT_YEL_GRN: begin
                    data_next.red   = in_data.q;
                    data_next.green = in_data.val;
                    data_next.blue  = in_data.p;
                end
                SXT_GRN_CYN: begin
                    data_next.red   = in_data.p;
                    data_next.green = in_data.val;
                    data_next.blue  = in_data.t;
                end
                SXT_CYN_BLU: begin
                    data_next.red   = in_data.p;
                    data_next.green = in_data.q;
                    data_next.blue  = in_data.val;
                end
                SXT_BLU_MAG: begin
                    data_next.red   = in_data.t;
                    data_next.green = in_data.p;
                    data_next.blue  = in_data.val;
                end
                default: begin
                    data_next.red   = in_data.val;
                    data_next.green = in_data.p;
                    data_next.blue  = in_data.q;
                end
            endcase
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    // A taken item always shows up at the output next cycle
    a_take_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && in_valid && in_ready |=> out_valid)
        else $error("perm: taken item did not reach output");

    // Nothing appears at the output without an item taken
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !in_valid && in_ready |=> !out_valid)
        else $error("perm: output valid without an item");

    // Gray pixels come out with three equal channels
    a_gray_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && in_valid && in_ready && in_data.gray |=>
        (out_data.red == out_data.green) && (out_data.green == out_data.blue))
        else $error("perm: gray pixel with unequal channels");

    // One channel always carries the value level
    a_max_is_val: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && in_valid && in_ready |=>
        (out_data.red == $past(in_data.val)) || (out_data.green == $past(in_data.val)) ||
        (out_data.blue == $past(in_data.val)))
        else $error("perm: no channel equals value");
`endif

endmodule

FILE: hw/rtl/hsv_to_rgb_8bit.sv
// Top level: four-stage HSV to RGB pixel pipeline with stream handshakes.
//
//  channel | dir | tdata fields (low bit first)              | width
//  --------+-----+--------------------------------------------+------
//  s_      | in  | hue[7:0], saturation[15:8], brightness[23:16] | 24
//  m_      | out | red[7:0], green[15:8], blue[23:16]         | 24
//
// One item per cycle while the output is not stalled, through the four register
// stages (sextant split, first multiply, second multiply, channel select).
// Reset clears only the stage valid bits; the datapath registers are not reset.
// Each stage has its own ready, so bubbles close up while the output is stalled
// and an item can be taken while a finished pixel still waits.
module hsv_to_rgb_8bit import hsv2rgb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue, saturation, brightness
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red, green, blue
);

    logic sxt_valid;
    logic sxt_ready;
    sxt_t sxt_data;
    logic scl_valid;
    logic scl_ready;
    scl_t scl_data;
    logic lvl_valid;
    logic lvl_ready;
    lvl_t lvl_data;
    rgb_t rgb_data;

    // Stage 1: sextant and remainder
    hsv2rgb_sextant u_sextant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .hue       (s_tdata[7:0]),
        .sat       (s_tdata[15:8]),
        .val       (s_tdata[23:16]),
        .out_valid (sxt_valid),
        .out_ready (sxt_ready),
        .out_data  (sxt_data)
    );

    // Stage 2: first products
    hsv2rgb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sxt_valid),
        .in_ready  (sxt_ready),
        .in_data   (sxt_data),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    // Stage 3: q and t
    hsv2rgb_level u_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_data   (scl_data),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_data  (lvl_data)
    );

    // Stage 4: channel select and output register
    hsv2rgb_perm u_perm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lvl_valid),
        .in_ready  (lvl_ready),
        .in_data   (lvl_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb_data)
    );

    assign m_tdata = rgb_data;

endmodule
